/* hdl/tun_pkg.sv */
// Package for the triangle unit normal block: field widths, stage counts,
// register addresses and the structs passed between pipeline sections.
// No dependencies.
package tun_pkg;

  localparam int COORD_W      = 16;
  localparam int EDGE_W       = 17;
  localparam int PROD_W       = 34;
  localparam int MAG_W        = 34;
  localparam int SHIFT_W      = 5;
  localparam int U_W          = 16;
  localparam int SQ_W         = 32;
  localparam int SUM_W        = 34;
  localparam int QUO_W        = 31;
  localparam int ROOT_W       = 32;
  localparam int FRONT_STAGES = 6;
  localparam int DIV_STAGES   = 31;
  localparam int SQRT_STAGES  = 16;
  localparam int PADDR_W      = 3;

  localparam logic [PADDR_W-1:0]        MIN_LEN_ADDR = 3'd0;
  localparam logic signed [COORD_W-1:0] UNIT_Q14     = 16'sd16384;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
    logic signed [COORD_W-1:0] c_x;
    logic signed [COORD_W-1:0] c_y;
    logic signed [COORD_W-1:0] c_z;
  } corner_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } side_t;

  typedef struct packed {
    logic [2:0][SQ_W-1:0] usq;
    logic [SUM_W-1:0]     s;
    side_t                side;
  } front_t;

  typedef struct packed {
    logic [2:0][QUO_W-1:0] quo;
    side_t                 side;
  } div_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] norm_x;
    logic signed [COORD_W-1:0] norm_y;
    logic signed [COORD_W-1:0] norm_z;
    logic                      degenerate;
  } result_t;

endpackage

/* hdl/tun_tri_if.sv */
// Request channel carrying one triangle as three corners in signed Q8.8.
// Depends on nothing; used by the top level.
interface tun_tri_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] a_x;
  logic signed [15:0] a_y;
  logic signed [15:0] a_z;
  logic signed [15:0] b_x;
  logic signed [15:0] b_y;
  logic signed [15:0] b_z;
  logic signed [15:0] c_x;
  logic signed [15:0] c_y;
  logic signed [15:0] c_z;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                output ready);
endinterface

/* hdl/tun_norm_if.sv */
// Result channel carrying one unit normal in signed Q1.14 and a degenerate flag.
// Depends on nothing; used by the top level.
interface tun_norm_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;
  logic               degenerate;

  modport source (output valid, norm_x, norm_y, norm_z, degenerate, input ready);
  modport sink (input valid, norm_x, norm_y, norm_z, degenerate, output ready);
endinterface

/* hdl/tun_front.sv */
// Front section: edges, cross product, block scaling, squares and the
// degenerate test, six register stages. Depends on tun_pkg.
module tun_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tun_pkg::corner_t in_data,
  input  logic [31:0]      min_length_sq,
  output logic             out_valid,
  input  logic             out_ready,
  output tun_pkg::front_t  out_data
);

  logic [tun_pkg::FRONT_STAGES:1]   v;
  logic [tun_pkg::FRONT_STAGES+1:1] adv;

  // A stage loads when it is empty or its content moves on.
  assign adv[tun_pkg::FRONT_STAGES+1] = out_ready;
  for (genvar i = 1; i <= tun_pkg::FRONT_STAGES; i++) begin : g_adv
    assign adv[i] = !v[i] || adv[i+1];
  end
  assign in_ready  = adv[1];
  assign out_valid = v[tun_pkg::FRONT_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[1]) v[1] <= in_valid;
      for (int i = 2; i <= tun_pkg::FRONT_STAGES; i++) begin
        if (adv[i]) v[i] <= v[i-1];
      end
    end
  end

  // Stage 1: edge vectors.
  logic signed [tun_pkg::EDGE_W-1:0] ex, ey, ez, fx, fy, fz;
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      ex <= $signed({in_data.b_x[15], in_data.b_x}) - $signed({in_data.a_x[15], in_data.a_x});
      ey <= $signed({in_data.b_y[15], in_data.b_y}) - $signed({in_data.a_y[15], in_data.a_y});
      ez <= $signed({in_data.b_z[15], in_data.b_z}) - $signed({in_data.a_z[15], in_data.a_z});
      fx <= $signed({in_data.c_x[15], in_data.c_x}) - $signed({in_data.a_x[15], in_data.a_x});
      fy <= $signed({in_data.c_y[15], in_data.c_y}) - $signed({in_data.a_y[15], in_data.a_y});
      fz <= $signed({in_data.c_z[15], in_data.c_z}) - $signed({in_data.a_z[15], in_data.a_z});
    end
  end

  // Stage 2: the six partial products of the cross product.
  logic signed [tun_pkg::PROD_W-1:0] m_yz, m_zy, m_zx, m_xz, m_xy, m_yx;
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      m_yz <= ey * fz;
      m_zy <= ez * fy;
      m_zx <= ez * fx;
      m_xz <= ex * fz;
      m_xy <= ex * fy;
      m_yx <= ey * fx;
    end
  end

  // Stage 3: cross product components as magnitude and sign.
  logic signed [tun_pkg::PROD_W:0] p [3];
  logic [tun_pkg::MAG_W-1:0]       mag3 [3];
  logic [2:0]                      neg3;

  always_comb begin
    p[0] = $signed({m_yz[33], m_yz}) - $signed({m_zy[33], m_zy});
    p[1] = $signed({m_zx[33], m_zx}) - $signed({m_xz[33], m_xz});
    p[2] = $signed({m_xy[33], m_xy}) - $signed({m_yx[33], m_yx});
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int l = 0; l < 3; l++) begin
        mag3[l] <= p[l][tun_pkg::PROD_W] ? tun_pkg::MAG_W'(-p[l])
                                         : tun_pkg::MAG_W'(p[l]);
        neg3[l] <= p[l][tun_pkg::PROD_W];
      end
    end
  end

  // Stage 4: shift all three right until every magnitude fits in 16 bits.
  logic [tun_pkg::MAG_W-1:0]   orv;
  logic [tun_pkg::SHIFT_W-1:0] k;
  logic [tun_pkg::U_W-1:0]     u4 [3];
  logic [2:0]                  neg4;
  logic                        small4;

  always_comb begin
    orv = mag3[0] | mag3[1] | mag3[2];
    k   = '0;
    for (int h = tun_pkg::U_W; h < tun_pkg::MAG_W; h++) begin
      if (orv[h]) k = tun_pkg::SHIFT_W'(h - (tun_pkg::U_W - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int l = 0; l < 3; l++) begin
        u4[l] <= tun_pkg::U_W'(mag3[l] >> k);
      end
      neg4   <= neg3;
      small4 <= (orv[tun_pkg::MAG_W-1:tun_pkg::U_W] == '0);
    end
  end

  // Stage 5: squares.
  logic [tun_pkg::SQ_W-1:0] sq5 [3];
  logic [2:0]               neg5;
  logic                     small5;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      for (int l = 0; l < 3; l++) begin
        sq5[l] <= u4[l] * u4[l];
      end
      neg5   <= neg4;
      small5 <= small4;
    end
  end

  // Stage 6: squared length and threshold. Unscaled vectors only can be small.
  logic [tun_pkg::SUM_W-1:0] sum6;
  assign sum6 = tun_pkg::SUM_W'(sq5[0]) + tun_pkg::SUM_W'(sq5[1])
              + tun_pkg::SUM_W'(sq5[2]);

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      for (int l = 0; l < 3; l++) begin
        out_data.usq[l] <= sq5[l];
      end
      out_data.s          <= sum6;
      out_data.side.neg   <= neg5;
      out_data.side.degen <= small5 && (sum6 <= tun_pkg::SUM_W'(min_length_sq));
    end
  end

endmodule

/* hdl/tun_div.sv */
// Pipelined restoring divider, one quotient bit per stage for three lanes:
// quo = floor(usq * 2^30 / s). Depends on tun_pkg.
module tun_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tun_pkg::front_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output tun_pkg::div_t   out_data
);

  localparam int N = tun_pkg::DIV_STAGES;

  logic [N-1:0] v;
  logic [N:0]   adv;

  logic [tun_pkg::SUM_W-1:0] rem  [N][3];
  logic [tun_pkg::QUO_W-1:0] quo  [N][3];
  logic [tun_pkg::SUM_W-1:0] sd   [N];
  tun_pkg::side_t            side [N];

  assign adv[N] = out_ready;

  for (genvar j = 0; j < N; j++) begin : g_stage
    logic [tun_pkg::SUM_W:0]   trial [3];
    logic [tun_pkg::QUO_W-1:0] q_in  [3];
    logic [tun_pkg::SUM_W-1:0] s_in;
    logic                      v_in;
    tun_pkg::side_t            side_in;
    logic [2:0]                ge;

    assign adv[j] = !v[j] || adv[j+1];

    // The first stage yields the integer bit; the rest shift in one bit each.
    if (j == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          trial[l] = (tun_pkg::SUM_W+1)'(in_data.usq[l]);
          q_in[l]  = '0;
        end
        s_in    = in_data.s;
        v_in    = in_valid;
        side_in = in_data.side;
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          trial[l] = {rem[j-1][l], 1'b0};
          q_in[l]  = quo[j-1][l];
        end
        s_in    = sd[j-1];
        v_in    = v[j-1];
        side_in = side[j-1];
      end
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        ge[l] = trial[l] >= (tun_pkg::SUM_W+1)'(s_in);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (adv[j]) begin
        v[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[j]) begin
        for (int l = 0; l < 3; l++) begin
          rem[j][l] <= ge[l] ? tun_pkg::SUM_W'(trial[l] - (tun_pkg::SUM_W+1)'(s_in))
                             : tun_pkg::SUM_W'(trial[l]);
          quo[j][l] <= {q_in[l][tun_pkg::QUO_W-2:0], ge[l]};
        end
        sd[j]   <= s_in;
        side[j] <= side_in;
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v[N-1];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      out_data.quo[l] = quo[N-1][l];
    end
    out_data.side = side[N-1];
  end

endmodule

/* hdl/tun_sqrt.sv */
// Pipelined integer square root, two radicand bits per stage for three lanes,
// then rounding, sign and fallback in the output register. Depends on tun_pkg.
module tun_sqrt (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tun_pkg::div_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output tun_pkg::result_t out_data
);

  localparam int N = tun_pkg::SQRT_STAGES;

  logic [N:0]   v;
  logic [N+1:0] adv;

  logic [tun_pkg::ROOT_W-1:0] rem  [N][3];
  logic [tun_pkg::ROOT_W-1:0] res  [N][3];
  tun_pkg::side_t             side [N];

  assign adv[N+1] = out_ready;

  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam logic [tun_pkg::ROOT_W-1:0] ONE =
      tun_pkg::ROOT_W'(1) << (2 * (N - 1 - j));

    logic [tun_pkg::ROOT_W-1:0] rem_in [3];
    logic [tun_pkg::ROOT_W-1:0] res_in [3];
    logic [tun_pkg::ROOT_W-1:0] trial  [3];
    logic                       v_in;
    tun_pkg::side_t             side_in;

    assign adv[j] = !v[j] || adv[j+1];

    if (j == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          rem_in[l] = tun_pkg::ROOT_W'(in_data.quo[l]);
          res_in[l] = '0;
        end
        v_in    = in_valid;
        side_in = in_data.side;
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          rem_in[l] = rem[j-1][l];
          res_in[l] = res[j-1][l];
        end
        v_in    = v[j-1];
        side_in = side[j-1];
      end
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        trial[l] = res_in[l] + ONE;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (adv[j]) begin
        v[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[j]) begin
        for (int l = 0; l < 3; l++) begin
          if (rem_in[l] >= trial[l]) begin
            rem[j][l] <= rem_in[l] - trial[l];
            res[j][l] <= tun_pkg::ROOT_W'(({1'b0, res_in[l]} + {ONE, 1'b0}) >> 1);
          end else begin
            rem[j][l] <= rem_in[l];
            res[j][l] <= res_in[l] >> 1;
          end
        end
        side[j] <= side_in;
      end
    end
  end

  // Output stage: t = (isqrt + 1) / 2 is the rounded Q1.14 magnitude.
  logic [tun_pkg::COORD_W-1:0]       t   [3];
  logic signed [tun_pkg::COORD_W-1:0] sgn [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      t[l]   = tun_pkg::COORD_W'(({1'b0, res[N-1][l][16:0]} + 18'd1) >> 1);
      sgn[l] = side[N-1].neg[l] ? -$signed(t[l]) : $signed(t[l]);
    end
  end

  assign adv[N] = !v[N] || adv[N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[N] <= 1'b0;
    end else if (adv[N]) begin
      v[N] <= v[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[N]) begin
      if (side[N-1].degen) begin
        out_data.norm_x     <= '0;
        out_data.norm_y     <= tun_pkg::UNIT_Q14;
        out_data.norm_z     <= '0;
        out_data.degenerate <= 1'b1;
      end else begin
        out_data.norm_x     <= sgn[0];
        out_data.norm_y     <= sgn[1];
        out_data.norm_z     <= sgn[2];
        out_data.degenerate <= 1'b0;
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v[N];

endmodule

/* hdl/triangle_unit_normal_top.sv */
// Top level of the triangle unit normal block: channels, the threshold
// register and three pipeline sections. Depends on tun_pkg, tun_tri_if,
// tun_norm_if, tun_front, tun_div and tun_sqrt.
//
// Usage: each request on the corner channel carries one triangle (corners A,
// B, C in signed Q8.8). For every request one result leaves on the normal
// channel, in order: the unit normal of (B-A) x (C-A) in signed Q1.14, or
// (0, 1, 0) with degenerate set when the squared cross length, in units of
// 2^-32, is at or below min_length_sq (APB byte address 0).
// From acceptance a request passes the cross product and threshold test, the
// divider (one quotient bit per stage) and the square root (two radicand
// bits per stage) plus the output register. Throughput is one triangle per
// cycle while the receiver does not stall the normal channel.
// Every stage carries a valid bit and loads when it is empty or its content
// moves on, so a stalled receiver fills the bubbles first and then holds
// corner.ready low; nothing is dropped or repeated.
// Reset empties the pipeline and clears min_length_sq, so only triangles of
// zero area count as degenerate until the register is written.
module triangle_unit_normal_top (
  input  logic                        clk,
  input  logic                        rst,
  tun_tri_if.sink                     corner,
  tun_norm_if.source                  normal,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tun_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [31:0] min_length_sq;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length_sq <= '0;
    end else if (psel && penable && pwrite && pready && paddr == tun_pkg::MIN_LEN_ADDR) begin
      min_length_sq <= pwdata;
    end
  end

  assign prdata = (paddr == tun_pkg::MIN_LEN_ADDR) ? min_length_sq : '0;

  tun_pkg::corner_t  corner_data;
  tun_pkg::front_t   front_data;
  tun_pkg::div_t     div_data;
  tun_pkg::result_t  result_data;
  logic              front_valid, front_ready;
  logic              div_valid, div_ready;

  always_comb begin
    corner_data.a_x = corner.a_x;
    corner_data.a_y = corner.a_y;
    corner_data.a_z = corner.a_z;
    corner_data.b_x = corner.b_x;
    corner_data.b_y = corner.b_y;
    corner_data.b_z = corner.b_z;
    corner_data.c_x = corner.c_x;
    corner_data.c_y = corner.c_y;
    corner_data.c_z = corner.c_z;
  end

  tun_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (corner.valid),
    .in_ready      (corner.ready),
    .in_data       (corner_data),
    .min_length_sq (min_length_sq),
    .out_valid     (front_valid),
    .out_ready     (front_ready),
    .out_data      (front_data)
  );

  tun_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_data  (div_data)
  );

  tun_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .in_data   (div_data),
    .out_valid (normal.valid),
    .out_ready (normal.ready),
    .out_data  (result_data)
  );

  assign normal.norm_x     = result_data.norm_x;
  assign normal.norm_y     = result_data.norm_y;
  assign normal.norm_z     = result_data.norm_z;
  assign normal.degenerate = result_data.degenerate;

  // The pipeline is empty right after reset.
  a_empty_after_reset: assert property (@(posedge clk) $past(rst) |-> !normal.valid)
    else $error("result valid right after reset");

  a_fallback: assert property (@(posedge clk) disable iff (rst)
    normal.valid && normal.degenerate |->
      normal.norm_x == 16'sd0 && normal.norm_y == tun_pkg::UNIT_Q14 &&
      normal.norm_z == 16'sd0)
    else $error("degenerate result without fallback normal");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    normal.valid |->
      normal.norm_x >= -16'sd16384 && normal.norm_x <= 16'sd16384 &&
      normal.norm_y >= -16'sd16384 && normal.norm_y <= 16'sd16384 &&
      normal.norm_z >= -16'sd16384 && normal.norm_z <= 16'sd16384)
    else $error("normal component outside unit range");

  // A result held by a stalled receiver is not overwritten.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    normal.valid && !normal.ready |=> normal.valid && $stable(result_data))
    else $error("stalled result changed");

endmodule
